// ===== design/rast_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants for the lazy range add/assign/sum tree.
package rast_pkg;

  localparam int IDX_W = 17;
  localparam int OPV_W = 32;
  localparam int VAL_W = 64;
  localparam int CMD_W = 2;

  localparam int DEF_MAX_ELEMENTS = 65536;
  localparam int IDX_CAP = 131071;
  localparam int CNT_RESET = 65536;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW = 2;
  localparam int STK_DEPTH = 32;
  localparam int STK_AW = 5;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ASSIGN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY_ALT = 2'd3;

  typedef enum logic [1:0] {OP_ADD, OP_ASSIGN, OP_QUERY} op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] last;
    logic [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] sum;
    logic [VAL_W-1:0] add_tag;
    logic [VAL_W-1:0] asg_val;
    logic             asg_vld;
  } node_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic q_full;
    logic clearing;
  } fe_ctl_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_VISIT, ST_QACC, ST_PD_RD, ST_MUL_LO, ST_MUL_HI,
    ST_AP_WR, ST_DESCEND, ST_RET, ST_RC_LEFT, ST_RC_RIGHT, ST_RC_WR, ST_OUT
  } state_t;

  typedef enum logic [1:0] {AP_NODE, AP_LEFT, AP_RIGHT} ap_sel_t;

endpackage

// ===== design/rast_in_if.sv =====
`timescale 1ns / 1ps
// Command channel interface.
interface rast_in_if;
  import rast_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [IDX_W-1:0]        range_first;
  logic [IDX_W-1:0]        range_last;
  logic signed [OPV_W-1:0] operand_value;
  modport source(output valid, command, range_first, range_last, operand_value,
                 input ready);
  modport sink(input valid, command, range_first, range_last, operand_value,
               output ready);
endinterface

// ===== design/rast_out_if.sv =====
`timescale 1ns / 1ps
// Result channel interface.
interface rast_out_if;
  import rast_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] range_sum;
  modport source(output valid, range_sum, input ready);
  modport sink(input valid, range_sum, output ready);
endinterface

// ===== design/rast_cfg_if.sv =====
`timescale 1ns / 1ps
// Element count write channel interface.
interface rast_cfg_if;
  import rast_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] element_count;
  modport source(output valid, element_count, input ready);
  modport sink(input valid, element_count, output ready);
endinterface

// ===== design/rast_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts commands, decodes the opcode and widens the operand.
module rast_front (
  rast_in_if.sink           in_ch,
  input  rast_pkg::fe_ctl_t ctl,
  output logic              push,
  output rast_pkg::cmd_t    push_data
);
  import rast_pkg::*;

  assign in_ch.ready = !ctl.q_full && !ctl.clearing;
  assign push = in_ch.valid && in_ch.ready;

  always_comb begin
    case (in_ch.command)
      CMD_ADD:    push_data.op = OP_ADD;
      CMD_ASSIGN: push_data.op = OP_ASSIGN;
      default:    push_data.op = OP_QUERY;
    endcase
    push_data.first = in_ch.range_first;
    push_data.last  = in_ch.range_last;
    push_data.value = {{(VAL_W-OPV_W){in_ch.operand_value[OPV_W-1]}}, in_ch.operand_value};
  end
endmodule

// ===== design/rast_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between front end and tree engine.
module rast_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rast_pkg::cmd_t   push_data,
  input  logic             pop,
  output rast_pkg::cmd_t   pop_data,
  output rast_pkg::q_stat_t stat
);
  import rast_pkg::*;

  cmd_t            slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   cnt_r;

  assign stat.full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end
endmodule

// ===== design/rast_back.sv =====
`timescale 1ns / 1ps
// Tree engine: walks the lazy segment tree with an explicit stack over one node memory.
module rast_back #(
  parameter int MAX_ELEMENTS = rast_pkg::DEF_MAX_ELEMENTS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [rast_pkg::IDX_W-1:0] count,
  input  logic                       q_empty,
  input  rast_pkg::cmd_t             pop_data,
  output logic                       pop,
  output logic                       clearing,
  rast_out_if.source                 out_ch
);
  import rast_pkg::*;

  localparam int NODES  = 4 * MAX_ELEMENTS;
  localparam int NODE_W = $clog2(NODES);
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

  state_t state_r, state_nxt;

  node_t mem [NODES];
  node_t rd_data_r;
  logic              rd_en, wr_en;
  logic [NODE_W-1:0] rd_addr, wr_addr;
  node_t             wr_data, applied;

  logic [NODE_W-1:0] clr_addr_r;
  cmd_t              op_r;
  logic [NODE_W-1:0] cur_id_r;
  logic [IDX_W-1:0]  cur_l_r, cur_r_r;
  logic [NODE_W-1:0] tgt_id_r;
  logic [IDX_W-1:0]  tgt_len_r;
  logic              tag_asg_r;
  logic [VAL_W-1:0]  tag_val_r;
  ap_sel_t           ap_sel_r;
  logic [VAL_W-1:0]  prod_lo_r, prod_r, acc_r, lsum_r;
  logic              out_vld_r;
  logic [VAL_W-1:0]  out_sum_r;

  logic [STK_AW:0]   sp_r;
  logic [NODE_W-1:0] stk_id [STK_DEPTH];
  logic [IDX_W-1:0]  stk_l  [STK_DEPTH];
  logic [IDX_W-1:0]  stk_r  [STK_DEPTH];
  logic              stk_ph [STK_DEPTH];

  logic [STK_AW-1:0] top_idx, push_idx;
  logic [IDX_W:0]    mid_sum, f_mid_sum;
  logic [IDX_W-1:0]  mid, f_mid, cur_len, left_len, right_len;
  logic [NODE_W-1:0] left_id, right_id, f_id;
  logic              disjoint, covered, is_query, has_tag, stk_empty, top_ph, out_free;
  logic [IDX_W+OPV_W-1:0] mul_p;
  logic [OPV_W-1:0]  mul_b;

  assign push_idx  = sp_r[STK_AW-1:0];
  assign top_idx   = push_idx - 1'b1;
  assign stk_empty = (sp_r == '0);
  assign top_ph    = stk_ph[top_idx];
  assign f_id      = stk_id[top_idx];
  assign f_mid_sum = {1'b0, stk_l[top_idx]} + {1'b0, stk_r[top_idx]};
  assign f_mid     = f_mid_sum[IDX_W:1];

  assign mid_sum   = {1'b0, cur_l_r} + {1'b0, cur_r_r};
  assign mid       = mid_sum[IDX_W:1];
  assign cur_len   = cur_r_r - cur_l_r + 1'b1;
  assign left_len  = mid - cur_l_r + 1'b1;
  assign right_len = cur_r_r - mid;
  assign left_id   = {cur_id_r[NODE_W-2:0], 1'b0};
  assign right_id  = {cur_id_r[NODE_W-2:0], 1'b1};

  assign disjoint = (cur_r_r < op_r.first) || (cur_l_r > op_r.last);
  assign covered  = (cur_l_r >= op_r.first) && (cur_r_r <= op_r.last);
  assign is_query = (op_r.op == OP_QUERY);
  assign has_tag  = rd_data_r.asg_vld || (rd_data_r.add_tag != '0);
  assign out_free = !out_vld_r || out_ch.ready;

  assign mul_b = (state_r == ST_MUL_LO) ? tag_val_r[OPV_W-1:0] : tag_val_r[VAL_W-1:OPV_W];
  assign mul_p = tgt_len_r * mul_b;

  assign clearing        = (state_r == ST_CLEAR);
  assign out_ch.valid    = out_vld_r;
  assign out_ch.range_sum = out_sum_r;

  // tag applied to the node read back in rd_data_r
  always_comb begin
    applied = rd_data_r;
    if (tag_asg_r) begin
      applied.sum     = prod_r;
      applied.asg_val = tag_val_r;
      applied.asg_vld = 1'b1;
      applied.add_tag = '0;
    end else begin
      applied.sum = rd_data_r.sum + prod_r;
      if (rd_data_r.asg_vld) applied.asg_val = rd_data_r.asg_val + tag_val_r;
      else applied.add_tag = rd_data_r.add_tag + tag_val_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:    if (clr_addr_r == LAST_NODE) state_nxt = ST_IDLE;
      ST_IDLE:     if (!q_empty) state_nxt = ST_VISIT;
      ST_VISIT: begin
        if (disjoint) state_nxt = ST_RET;
        else if (covered) state_nxt = is_query ? ST_QACC : ST_MUL_LO;
        else state_nxt = ST_PD_RD;
      end
      ST_QACC:     state_nxt = ST_RET;
      ST_PD_RD:    state_nxt = has_tag ? ST_MUL_LO : ST_DESCEND;
      ST_MUL_LO:   state_nxt = ST_MUL_HI;
      ST_MUL_HI:   state_nxt = ST_AP_WR;
      ST_AP_WR: begin
        case (ap_sel_r)
          AP_LEFT:  state_nxt = ST_MUL_LO;
          AP_RIGHT: state_nxt = ST_DESCEND;
          default:  state_nxt = ST_RET;
        endcase
      end
      ST_DESCEND:  state_nxt = ST_VISIT;
      ST_RET: begin
        if (stk_empty) state_nxt = is_query ? ST_OUT : ST_IDLE;
        else if (!top_ph) state_nxt = ST_VISIT;
        else state_nxt = is_query ? ST_RET : ST_RC_LEFT;
      end
      ST_RC_LEFT:  state_nxt = ST_RC_RIGHT;
      ST_RC_RIGHT: state_nxt = ST_RC_WR;
      ST_RC_WR:    state_nxt = ST_RET;
      ST_OUT:      if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    rd_en   = 1'b0;
    rd_addr = cur_id_r;
    wr_en   = 1'b0;
    wr_addr = tgt_id_r;
    wr_data = applied;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
        wr_data = '0;
      end
      ST_IDLE:  pop = !q_empty;
      ST_VISIT: rd_en = !disjoint;
      ST_PD_RD: begin
        if (has_tag) begin
          wr_en   = 1'b1;
          wr_addr = cur_id_r;
          wr_data = '{sum: rd_data_r.sum, add_tag: '0, asg_val: '0, asg_vld: 1'b0};
          rd_en   = 1'b1;
          rd_addr = left_id;
        end
      end
      ST_AP_WR: begin
        wr_en = 1'b1;
        if (ap_sel_r == AP_LEFT) begin
          rd_en   = 1'b1;
          rd_addr = right_id;
        end
      end
      ST_RC_LEFT: begin
        rd_en   = 1'b1;
        rd_addr = left_id;
      end
      ST_RC_RIGHT: begin
        rd_en   = 1'b1;
        rd_addr = right_id;
      end
      ST_RC_WR: begin
        wr_en   = 1'b1;
        wr_addr = cur_id_r;
        wr_data = '{sum: lsum_r + rd_data_r.sum, add_tag: '0, asg_val: '0, asg_vld: 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      sp_r       <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
      if (state_r == ST_IDLE && !q_empty) sp_r <= '0;
      else if (state_r == ST_DESCEND) sp_r <= sp_r + 1'b1;
      else if (state_r == ST_RET && !stk_empty && top_ph) sp_r <= sp_r - 1'b1;
      if (state_r == ST_OUT && out_free) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          op_r     <= pop_data;
          cur_id_r <= NODE_W'(1);
          cur_l_r  <= IDX_W'(1);
          cur_r_r  <= count;
          acc_r    <= '0;
        end
      end
      ST_VISIT: begin
        if (!disjoint && covered && !is_query) begin
          tgt_id_r  <= cur_id_r;
          tgt_len_r <= cur_len;
          tag_asg_r <= (op_r.op == OP_ASSIGN);
          tag_val_r <= op_r.value;
          ap_sel_r  <= AP_NODE;
        end
      end
      ST_QACC: acc_r <= acc_r + rd_data_r.sum;
      ST_PD_RD: begin
        if (has_tag) begin
          tgt_id_r  <= left_id;
          tgt_len_r <= left_len;
          tag_asg_r <= rd_data_r.asg_vld;
          tag_val_r <= rd_data_r.asg_vld ? rd_data_r.asg_val + rd_data_r.add_tag
                                         : rd_data_r.add_tag;
          ap_sel_r  <= AP_LEFT;
        end
      end
      ST_MUL_LO: prod_lo_r <= VAL_W'(mul_p);
      ST_MUL_HI: prod_r <= prod_lo_r + {mul_p[OPV_W-1:0], {OPV_W{1'b0}}};
      ST_AP_WR: begin
        if (ap_sel_r == AP_LEFT) begin
          tgt_id_r  <= right_id;
          tgt_len_r <= right_len;
          ap_sel_r  <= AP_RIGHT;
        end
      end
      ST_DESCEND: begin
        stk_id[push_idx] <= cur_id_r;
        stk_l[push_idx]  <= cur_l_r;
        stk_r[push_idx]  <= cur_r_r;
        stk_ph[push_idx] <= 1'b0;
        cur_id_r         <= left_id;
        cur_r_r          <= mid;
      end
      ST_RET: begin
        if (!stk_empty) begin
          if (!top_ph) begin
            stk_ph[top_idx] <= 1'b1;
            cur_id_r        <= {f_id[NODE_W-2:0], 1'b1};
            cur_l_r         <= f_mid + 1'b1;
            cur_r_r         <= stk_r[top_idx];
          end else begin
            cur_id_r <= f_id;
            cur_l_r  <= stk_l[top_idx];
            cur_r_r  <= stk_r[top_idx];
          end
        end
      end
      ST_RC_RIGHT: lsum_r <= rd_data_r.sum;
      ST_OUT: if (out_free) out_sum_r <= acc_r;
      default: ;
    endcase
  end
endmodule

// ===== design/range_add_assign_sum_tree.sv =====
`timescale 1ns / 1ps
// Range add / range assign / range sum engine over a lazy segment tree, top level.
// After reset the node memory is swept to zero, one node per cycle over all
// 4*MAX_ELEMENTS nodes, and no command is taken until that ends. A command then
// passes over each node it skips, reads a covered node whole for a query or tags
// it otherwise, and splits a partial node, first pushing any pending tag to its
// two children and, for an add or assign, summing the children again afterwards.
// The node memory has one read and one write port, one shared 17x32 multiplier
// scales each tag by its node length, and commands run one at a time. Commands
// queue while one runs, until the queue is full; a finished sum waits in an output
// register without holding up the engine until the next query is done.
module range_add_assign_sum_tree #(
  parameter int MAX_ELEMENTS = rast_pkg::DEF_MAX_ELEMENTS
) (
  input  logic        clk,
  input  logic        rst_n,
  rast_in_if.sink     in_ch,
  rast_out_if.source  out_ch,
  rast_cfg_if.sink    cfg_ch
);
  import rast_pkg::*;

  localparam logic [IDX_W-1:0] CNT_CAP =
    IDX_W'((MAX_ELEMENTS > IDX_CAP) ? IDX_CAP : MAX_ELEMENTS);
  localparam logic [IDX_W-1:0] CNT_RST =
    IDX_W'((MAX_ELEMENTS > CNT_RESET) ? CNT_RESET : MAX_ELEMENTS);

  logic [IDX_W-1:0] count_r, count_nxt;
  logic    push, pop, clearing;
  cmd_t    push_data, pop_data;
  q_stat_t q_stat;
  fe_ctl_t fe_ctl;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    if (cfg_ch.element_count == '0) count_nxt = IDX_W'(1);
    else if (cfg_ch.element_count > CNT_CAP) count_nxt = CNT_CAP;
    else count_nxt = cfg_ch.element_count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= CNT_RST;
    else if (cfg_ch.valid && cfg_ch.ready) count_r <= count_nxt;
  end

  assign fe_ctl.q_full   = q_stat.full;
  assign fe_ctl.clearing = clearing;

  rast_front u_front (
    .in_ch     (in_ch),
    .ctl       (fe_ctl),
    .push      (push),
    .push_data (push_data)
  );

  rast_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  rast_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .count    (count_r),
    .q_empty  (q_stat.empty),
    .pop_data (pop_data),
    .pop      (pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );
endmodule

// ===== design/rast_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the range tree engine, bound to the top level.
module rast_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [rast_pkg::CMD_W-1:0] in_command,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rast_pkg::VAL_W-1:0] out_sum
);
  import rast_pkg::*;

  logic [3:0] q_cnt_r;
  logic       q_in, q_out;

  assign q_in  = in_valid && in_ready &&
                 (in_command == CMD_QUERY || in_command == CMD_QUERY_ALT);
  assign q_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) q_cnt_r <= '0;
    else if (q_in && !q_out) q_cnt_r <= q_cnt_r + 1'b1;
    else if (q_out && !q_in) q_cnt_r <= q_cnt_r - 1'b1;
  end

  a_no_take_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("command taken right after reset");
  a_no_result_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");
  a_result_has_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> q_cnt_r != '0)
    else $error("result transfer without an outstanding query");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sum))
    else $error("result changed while stalled");
endmodule

bind range_add_assign_sum_tree rast_checker u_rast_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_command (in_ch.command),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sum    (out_ch.range_sum)
);

// ===== tb/sv/rast_tree_checker.sv =====
`timescale 1ns / 1ps
// Checker for the range add/assign/sum tree: mirrors the lazy tree and compares sums.
module rast_tree_checker #(
  parameter int MAX_ELEMENTS = rast_pkg::DEF_MAX_ELEMENTS
) (
  input  logic clk,
  input  logic rst_n,
  rast_in_if   in_ch,
  rast_out_if  out_ch,
  rast_cfg_if  cfg_ch,
  output int   fail_count,
  output int   sums_owed
);
  import rast_pkg::*;

  localparam int NODES = 4 * MAX_ELEMENTS;

  bit [63:0] node_total [NODES];
  bit [63:0] add_tag [NODES];
  bit [63:0] asg_tag [NODES];
  bit        asg_set [NODES];
  int unsigned elem_cnt = MAX_ELEMENTS < CNT_RESET ? MAX_ELEMENTS : CNT_RESET;
  logic [63:0] sum_queue [$];

  assign sums_owed = sum_queue.size();

  function automatic void tag_assign(int unsigned id, bit [63:0] len, bit [63:0] v);
    if (id >= NODES) return;
    node_total[id] = len * v;
    asg_tag[id] = v;
    asg_set[id] = 1'b1;
    add_tag[id] = '0;
  endfunction

  function automatic void tag_add(int unsigned id, bit [63:0] len, bit [63:0] v);
    if (id >= NODES) return;
    node_total[id] += len * v;
    if (asg_set[id]) asg_tag[id] += v;
    else add_tag[id] += v;
  endfunction

  function automatic void push_tags(int unsigned id, int unsigned l, int unsigned r,
                                    int unsigned m);
    bit [63:0] llen;
    bit [63:0] rlen;
    llen = m - l + 1;
    rlen = r - m;
    if (id >= NODES) return;
    if (asg_set[id]) begin
      tag_assign(2 * id, llen, asg_tag[id]);
      tag_assign(2 * id + 1, rlen, asg_tag[id]);
      asg_set[id] = 1'b0;
      asg_tag[id] = '0;
    end
    if (add_tag[id] != 0) begin
      tag_add(2 * id, llen, add_tag[id]);
      tag_add(2 * id + 1, rlen, add_tag[id]);
      add_tag[id] = '0;
    end
  endfunction

  function automatic void apply_range(int unsigned id, int unsigned l, int unsigned r,
                                      int unsigned u, int unsigned v, bit [63:0] val,
                                      bit asg);
    int unsigned m;
    if (id >= NODES) return;
    if (r < u || l > v) return;
    if (l >= u && r <= v) begin
      if (asg) tag_assign(id, r - l + 1, val);
      else tag_add(id, r - l + 1, val);
      return;
    end
    m = (l + r) / 2;
    push_tags(id, l, r, m);
    apply_range(2 * id, l, m, u, v, val, asg);
    apply_range(2 * id + 1, m + 1, r, u, v, val, asg);
    if (2 * id + 1 < NODES) node_total[id] = node_total[2 * id] + node_total[2 * id + 1];
  endfunction

  function automatic bit [63:0] range_total(int unsigned id, int unsigned l, int unsigned r,
                                            int unsigned u, int unsigned v);
    int unsigned m;
    if (id >= NODES) return '0;
    if (r < u || l > v) return '0;
    if (l >= u && r <= v) return node_total[id];
    m = (l + r) / 2;
    push_tags(id, l, r, m);
    return range_total(2 * id, l, m, u, v) + range_total(2 * id + 1, m + 1, r, u, v);
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    bit [63:0] opv;
    logic [63:0] want;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.element_count == 0) elem_cnt = 1;
        else if (cfg_ch.element_count > MAX_ELEMENTS) elem_cnt = MAX_ELEMENTS;
        else elem_cnt = cfg_ch.element_count;
      end
      if (in_ch.valid && in_ch.ready) begin
        opv = {{32{in_ch.operand_value[31]}}, in_ch.operand_value};
        case (in_ch.command)
          CMD_ADD: apply_range(1, 1, elem_cnt, in_ch.range_first, in_ch.range_last, opv, 1'b0);
          CMD_ASSIGN: apply_range(1, 1, elem_cnt, in_ch.range_first, in_ch.range_last, opv,
                                  1'b1);
          default: sum_queue.push_back(range_total(1, 1, elem_cnt, in_ch.range_first,
                                                   in_ch.range_last));
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (sum_queue.size() == 0) begin
          $error("range_sum transfer with no query pending: actual %0d", out_ch.range_sum);
          fail_count++;
        end else begin
          want = sum_queue.pop_front();
          if (out_ch.range_sum !== want) begin
            $error("range_sum mismatch: expected %0d actual %0d", $signed(want),
                   out_ch.range_sum);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench top: drives commands and element counts, gives the verdict.
module tb;
  import rast_pkg::*;

  localparam longint CYCLE_LIMIT = 20_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   calm = 1'b0;
  int   fails;
  int   owed;
  longint cycles = 0;
  int unsigned cur_cnt = CNT_RESET;

  rast_in_if  in_ch ();
  rast_out_if out_ch ();
  rast_cfg_if cfg_ch ();

  range_add_assign_sum_tree dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  rast_tree_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fails), .sums_owed(owed)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_ADD;
    in_ch.range_first = '0;
    in_ch.range_last = '0;
    in_ch.operand_value = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.element_count = '0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) out_ch.ready <= calm || ($urandom_range(99) >= 16);

  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] f, logic [IDX_W-1:0] l,
                          logic [OPV_W-1:0] v);
    if (!calm && $urandom_range(99) < 16) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.range_first <= f;
    in_ch.range_last <= l;
    in_ch.operand_value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    send_cmd(CMD_QUERY, 1, 1, '0);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_count(logic [IDX_W-1:0] c);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.element_count <= c;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cur_cnt = (c == 0) ? 1 : (c > CNT_RESET ? CNT_RESET : c);
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(99) < 8) return IDX_W'($urandom);
    return IDX_W'($urandom_range(1, cur_cnt));
  endfunction

  task automatic random_cmds(int n);
    logic [IDX_W-1:0] f;
    logic [IDX_W-1:0] l;
    logic [IDX_W-1:0] t;
    logic [CMD_W-1:0] c;
    int r;
    for (int i = 0; i < n; i++) begin
      f = pick_index();
      l = pick_index();
      if (f > l && $urandom_range(99) < 85) begin
        t = f; f = l; l = t;
      end
      r = $urandom_range(99);
      c = r < 35 ? CMD_ADD : r < 65 ? CMD_ASSIGN : r < 95 ? CMD_QUERY : CMD_QUERY_ALT;
      send_cmd(c, f, l, $urandom);
    end
  endtask

  initial begin
    logic [IDX_W-1:0] counts [7] = '{1, 2, 13, 1000, 0, 131071, 37};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_cmd(CMD_ASSIGN, 1, 1, 32'h7fffffff);
    send_cmd(CMD_ASSIGN, 65536, 65536, 32'h80000000);
    send_cmd(CMD_QUERY, 1, 65536, '0);
    send_cmd(CMD_ADD, 1, 65536, 32'hffffffff);
    send_cmd(CMD_QUERY_ALT, 0, 131071, 32'h12345678);
    send_cmd(CMD_ASSIGN, 100, 200, '0);
    send_cmd(CMD_QUERY, 99, 201, '0);
    send_cmd(CMD_ADD, 0, 0, 32'h55555555);
    send_cmd(CMD_ASSIGN, 70000, 131071, 32'haaaaaaaa);
    send_cmd(CMD_QUERY, 300, 200, '0);
    send_cmd(CMD_QUERY, 65537, 131071, '0);
    send_cmd(CMD_ADD, 2, 65535, 32'h80000000);
    send_cmd(CMD_ASSIGN, 32768, 32769, 32'h7fffffff);
    send_cmd(CMD_ADD, 0, 131071, 32'h7fffffff);
    send_cmd(CMD_QUERY, 1, 131071, '0);
    send_cmd(CMD_QUERY, 32768, 32768, '0);
    send_cmd(CMD_ASSIGN, 1, 65536, '0);
    send_cmd(CMD_QUERY, 1, 65536, '0);
    random_cmds(150);
    foreach (counts[k]) begin
      write_count(counts[k]);
      calm = (k == 3);
      random_cmds(170);
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (fails == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

// ===== range_add_assign_sum_tree.f =====
design/rast_pkg.sv
design/rast_in_if.sv
design/rast_out_if.sv
design/rast_cfg_if.sv
design/rast_front.sv
design/rast_queue.sv
design/rast_back.sv
design/range_add_assign_sum_tree.sv
design/rast_checker.sv
tb/sv/rast_tree_checker.sv
tb/sv/tb.sv
